>>> rtl/nta_pkg.sv
package nta_pkg;

  // Field widths
  localparam int ID_W   = 32;
  localparam int POS_W  = 24;
  localparam int PL_W   = 64;
  localparam int TIME_W = 32;
  localparam int RSSI_W = 16;
  localparam int RAD_W  = 23;
  localparam int R2_W   = 2 * RAD_W;
  localparam int CNT_W  = 6;
  localparam int TOT_W  = 64;
  localparam int STAT_W = 3;
  localparam int HIT_W  = 6;

  localparam logic [HIT_W-1:0]  MAX_RES       = 6'd32;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

  // Operation codes
  localparam logic [1:0] MODE_UPSERT = 2'd0;
  localparam logic [1:0] MODE_AGE    = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_REPORT   = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPSERTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_AGED     = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOMATCH  = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  z;
    logic [PL_W-1:0]          payload;
    logic [TIME_W-1:0]        seen;
    logic signed [RSSI_W-1:0] rssi;
  } entry_t;

  // Classified command; ent.seen carries now_time
  typedef struct packed {
    logic [1:0]      mode;
    entry_t          ent;
    logic [R2_W-1:0] r2;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    entry_t            ent;
    logic              last;
    logic [CNT_W-1:0]  count;
    logic [TOT_W-1:0]  obs;
    logic [TOT_W-1:0]  evi;
  } res_t;

endpackage

>>> rtl/neighbour_table_aging_radius_query.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------------
// in_      | in_valid / in_stall        | mode, node_id, pos_x/y/z, payload, ...
// out_     | out_valid / out_stall      | status, found_*, last, totals
// cfg_     | cfg_wr_en (no wait)        | cfg_wr_data -> timeout_ticks
//
// Per item: clear goes straight to its result; upsert scans held entries for a
// matching id; age-out reads and compacts every held entry; query reads, squares and
// compares each entry scanned, one entry at a time through the entry table read port.
// A two-deep command queue lets input transfers continue while the engine works.
// Reset (rst_n low, synchronous) empties the table and zeroes both totals.
// A stalled output holds the engine, once it has another result to present, until the waiting result is taken.
module neighbour_table_aging_radius_query #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [nta_pkg::TIME_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic [nta_pkg::ID_W-1:0]          in_node_id,
  input  logic signed [nta_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [nta_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [nta_pkg::POS_W-1:0]  in_pos_z,
  input  logic [nta_pkg::PL_W-1:0]          in_payload,
  input  logic [nta_pkg::TIME_W-1:0]        in_now_time,
  input  logic signed [nta_pkg::RSSI_W-1:0] in_rssi_level,
  input  logic [nta_pkg::RAD_W-1:0]         in_search_radius,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nta_pkg::STAT_W-1:0]        out_status,
  output logic [nta_pkg::ID_W-1:0]          out_found_id,
  output logic signed [nta_pkg::POS_W-1:0]  out_found_x,
  output logic signed [nta_pkg::POS_W-1:0]  out_found_y,
  output logic signed [nta_pkg::POS_W-1:0]  out_found_z,
  output logic [nta_pkg::PL_W-1:0]          out_found_payload,
  output logic [nta_pkg::TIME_W-1:0]        out_found_seen,
  output logic signed [nta_pkg::RSSI_W-1:0] out_found_rssi,
  output logic                              out_last,
  output logic [nta_pkg::CNT_W-1:0]         out_entry_count,
  output logic [nta_pkg::TOT_W-1:0]         out_observations_total,
  output logic [nta_pkg::TOT_W-1:0]         out_evictions_total
);
  import nta_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;
  res_t res;

  nta_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_node_id       (in_node_id),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_payload       (in_payload),
    .in_now_time      (in_now_time),
    .in_rssi_level    (in_rssi_level),
    .in_search_radius (in_search_radius),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop)
  );

  nta_back #(
    .DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res)
  );

  // Unpack the result register onto the ports
  assign out_status             = res.status;
  assign out_found_id           = res.ent.id;
  assign out_found_x            = res.ent.x;
  assign out_found_y            = res.ent.y;
  assign out_found_z            = res.ent.z;
  assign out_found_payload      = res.ent.payload;
  assign out_found_seen         = res.ent.seen;
  assign out_found_rssi         = res.ent.rssi;
  assign out_last               = res.last;
  assign out_entry_count        = res.count;
  assign out_observations_total = res.obs;
  assign out_evictions_total    = res.evi;

endmodule

>>> rtl/nta_front.sv
module nta_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [nta_pkg::ID_W-1:0]       in_node_id,
  input  logic signed [nta_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [nta_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [nta_pkg::POS_W-1:0] in_pos_z,
  input  logic [nta_pkg::PL_W-1:0]       in_payload,
  input  logic [nta_pkg::TIME_W-1:0]     in_now_time,
  input  logic signed [nta_pkg::RSSI_W-1:0] in_rssi_level,
  input  logic [nta_pkg::RAD_W-1:0]      in_search_radius,
  output logic                           q_valid,
  output nta_pkg::cmd_t                  q_cmd,
  input  logic                           q_pop
);
  import nta_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd_in;
  logic [R2_W-1:0] rad_ext;

  // Classify the incoming item and square the radius once up front
  always_comb begin
    rad_ext            = {{(R2_W-RAD_W){1'b0}}, in_search_radius};
    cmd_in.mode        = in_mode;
    cmd_in.ent.id      = in_node_id;
    cmd_in.ent.x       = in_pos_x;
    cmd_in.ent.y       = in_pos_y;
    cmd_in.ent.z       = in_pos_z;
    cmd_in.ent.payload = in_payload;
    cmd_in.ent.seen    = in_now_time;
    cmd_in.ent.rssi    = in_rssi_level;
    cmd_in.r2          = rad_ext * rad_ext;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = slot_r[rp_r];

  // Advance queue pointers
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cmd_in;
    end
  end

endmodule

>>> rtl/nta_back.sv
module nta_back #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [nta_pkg::TIME_W-1:0] cfg_wr_data,
  input  logic                       q_valid,
  input  nta_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output nta_pkg::res_t              out_res
);
  import nta_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  entry_t mem [DEPTH];
  entry_t rd_q;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     wr_r, wr_nxt;
  logic [CW-1:0]     held_r, held_nxt;
  logic [HIT_W-1:0]  hits_r, hits_nxt;
  cmd_t              cmd_r, cmd_nxt;
  entry_t            pend_r, pend_nxt;
  logic [STAT_W-1:0] fin_r, fin_nxt;
  logic [TOT_W-1:0]  ups_r, ups_nxt;
  logic [TOT_W-1:0]  evi_r, evi_nxt;
  logic [TIME_W-1:0] timeout_r;
  logic signed [POS_W:0] dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;
  logic [2*POS_W:0]  sx_r, sy_r, sz_r, sx_nxt, sy_nxt, sz_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa;
  entry_t            mem_wd;
  logic              out_free, scan_more, expired, hit;
  logic signed [2*POS_W+1:0] ex, ey, ez, prx, pry, prz;
  logic [2*POS_W+2:0] d2;
  logic [TIME_W:0]   expiry;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Datapath helpers
  always_comb begin
    ex     = dx_r;
    ey     = dy_r;
    ez     = dz_r;
    prx    = ex * ex;
    pry    = ey * ey;
    prz    = ez * ez;
    d2     = {2'b00, sx_r} + {2'b00, sy_r} + {2'b00, sz_r};
    hit    = d2 <= {{(2*POS_W+3-R2_W){1'b0}}, cmd_r.r2};
    expiry = {1'b0, rd_q.seen} + {1'b0, timeout_r};
    expired = expiry < {1'b0, cmd_r.ent.seen};
    scan_more = (idx_r < held_r) &&
                !((cmd_r.mode == MODE_QUERY) && (hits_r == MAX_RES));
  end

  // Sequence the scan, compaction and result transfers
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    wr_nxt    = wr_r;
    held_nxt  = held_r;
    hits_nxt  = hits_r;
    cmd_nxt   = cmd_r;
    pend_nxt  = pend_r;
    fin_nxt   = fin_r;
    ups_nxt   = ups_r;
    evi_nxt   = evi_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    dz_nxt    = dz_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sz_nxt    = sz_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = idx_r[AW-1:0];
    mem_wd    = cmd_r.ent;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt        = out_r;
    out_nxt.status = ST_REPORT;
    out_nxt.ent    = pend_r;
    out_nxt.last   = 1'b0;
    out_nxt.count  = CNT_W'(held_r);
    out_nxt.obs    = ups_r;
    out_nxt.evi    = evi_r;
    case (state_r)
      S_IDLE: begin
        out_nxt = out_r;
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_cmd;
          idx_nxt  = '0;
          wr_nxt   = '0;
          hits_nxt = '0;
          if (q_cmd.mode == MODE_CLEAR) begin
            held_nxt  = '0;
            fin_nxt   = ST_CLEARED;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        out_nxt = out_r;
        if (scan_more) begin
          mem_re    = 1'b1;
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_EMIT;
          case (cmd_r.mode)
            MODE_UPSERT: begin
              if (held_r == DEPTH_C) begin
                fin_nxt = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = held_r[AW-1:0];
                held_nxt = held_r + 1'b1;
                ups_nxt  = ups_r + 1'b1;
                fin_nxt  = ST_UPSERTED;
              end
            end
            MODE_AGE: begin
              held_nxt = wr_r;
              fin_nxt  = ST_AGED;
            end
            MODE_QUERY: begin
              fin_nxt = (hits_r == '0) ? ST_NOMATCH : ST_REPORT;
            end
            default: begin
              fin_nxt = ST_CLEARED;
            end
          endcase
        end
      end
      S_CHK: begin
        out_nxt = out_r;
        case (cmd_r.mode)
          MODE_UPSERT: begin
            if (rd_q.id == cmd_r.ent.id) begin
              mem_we    = 1'b1;
              ups_nxt   = ups_r + 1'b1;
              fin_nxt   = ST_UPSERTED;
              state_nxt = S_EMIT;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_SCAN;
            end
          end
          MODE_AGE: begin
            if (expired) begin
              evi_nxt = evi_r + 1'b1;
            end else begin
              mem_we = 1'b1;
              mem_wa = wr_r[AW-1:0];
              mem_wd = rd_q;
              wr_nxt = wr_r + 1'b1;
            end
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SCAN;
          end
          MODE_QUERY: begin
            dx_nxt    = {rd_q.x[POS_W-1], rd_q.x} - {cmd_r.ent.x[POS_W-1], cmd_r.ent.x};
            dy_nxt    = {rd_q.y[POS_W-1], rd_q.y} - {cmd_r.ent.y[POS_W-1], cmd_r.ent.y};
            dz_nxt    = {rd_q.z[POS_W-1], rd_q.z} - {cmd_r.ent.z[POS_W-1], cmd_r.ent.z};
            state_nxt = S_SQ;
          end
          default: begin
            state_nxt = S_SCAN;
          end
        endcase
      end
      S_SQ: begin
        out_nxt   = out_r;
        sx_nxt    = prx[2*POS_W:0];
        sy_nxt    = pry[2*POS_W:0];
        sz_nxt    = prz[2*POS_W:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!hit) begin
          out_nxt   = out_r;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end else if ((hits_r != '0) && !out_free) begin
          out_nxt = out_r;
        end else begin
          // Release the previous hit; this one becomes pending
          if (hits_r != '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            out_nxt = out_r;
          end
          pend_nxt  = rd_q;
          hits_nxt  = hits_r + 1'b1;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = fin_r;
          out_nxt.ent    = (fin_r == ST_REPORT) ? pend_r : '0;
          out_nxt.last   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          out_nxt = out_r;
        end
      end
      default: begin
        out_nxt   = out_r;
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      wr_r        <= '0;
      held_r      <= '0;
      hits_r      <= '0;
      ups_r       <= '0;
      evi_r       <= '0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      wr_r        <= wr_nxt;
      held_r      <= held_nxt;
      hits_r      <= hits_nxt;
      ups_r       <= ups_nxt;
      evi_r       <= evi_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
    fin_r  <= fin_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dz_r   <= dz_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    sz_r   <= sz_nxt;
    out_r  <= out_nxt;
  end

  // Entry table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[idx_r[AW-1:0]];
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= DEPTH_C) else $error("table count above depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r <= idx_r) else $error("compaction write ahead of read");

  a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r <= MAX_RES) else $error("query hit count overflow");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE)) else $error("table write while idle");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && out_free |=> out_valid_r && out_r.last)
    else $error("final result not presented");

endmodule
